// ===== rtl/des_round_key_schedule_core_assert.svh =====
// Assertion macros shared by the DES key schedule RTL.
// Included by the modules that check their own control logic; needs no package.
`ifndef DES_ROUND_KEY_SCHEDULE_CORE_ASSERT_SVH
`define DES_ROUND_KEY_SCHEDULE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked on the rising clock edge, disabled while reset is asserted.
`define DES_RKS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("DES key schedule assertion failed");
// Property checked on every rising clock edge, reset included.
`define DES_RKS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("DES key schedule assertion failed");
`else
`define DES_RKS_ASSERT(lbl, clk, rst_n, prop)
`define DES_RKS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/des_rks_pkg.sv =====
// Package for the DES round key schedule: payload types, control structs,
// the PC-1, PC-2 and shift tables, and the permutation functions. No dependencies.
`default_nettype none

package des_rks_pkg;

  // Input item: key and requested round.
  typedef struct packed {
    logic [63:0] cipher_key;
    logic [3:0]  round_index;
  } key_req_t;

  // Result item: the round subkey.
  typedef struct packed {
    logic [47:0] round_subkey;
  } subkey_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rotate;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } dp_status_t;

  // Left rotation of each half in each round.
  localparam logic [1:0] ROT_PER_ROUND [16] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  // PC-1 over the 56 non-parity key bits; entry j names key bit j + j/7.
  localparam logic [5:0] PC1_SEL [56] = '{
    6'd49, 6'd42, 6'd35, 6'd28, 6'd21, 6'd14, 6'd7,  6'd0,
    6'd50, 6'd43, 6'd36, 6'd29, 6'd22, 6'd15, 6'd8,  6'd1,
    6'd51, 6'd44, 6'd37, 6'd30, 6'd23, 6'd16, 6'd9,  6'd2,
    6'd52, 6'd45, 6'd38, 6'd31, 6'd55, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13, 6'd6,  6'd54, 6'd47, 6'd40, 6'd33,
    6'd26, 6'd19, 6'd12, 6'd5,  6'd53, 6'd46, 6'd39, 6'd32,
    6'd25, 6'd18, 6'd11, 6'd4,  6'd24, 6'd17, 6'd10, 6'd3
  };

  // PC-2 over the rotated 56-bit key, bit 0 being the most significant.
  localparam logic [5:0] PC2_SEL [48] = '{
    6'd13, 6'd16, 6'd10, 6'd23, 6'd0,  6'd4,  6'd2,  6'd27,
    6'd14, 6'd5,  6'd20, 6'd9,  6'd22, 6'd18, 6'd11, 6'd3,
    6'd25, 6'd7,  6'd15, 6'd6,  6'd26, 6'd19, 6'd12, 6'd1,
    6'd40, 6'd51, 6'd30, 6'd36, 6'd46, 6'd54, 6'd29, 6'd39,
    6'd50, 6'd44, 6'd32, 6'd47, 6'd43, 6'd48, 6'd38, 6'd55,
    6'd33, 6'd52, 6'd45, 6'd41, 6'd49, 6'd35, 6'd28, 6'd31
  };

  // PC-1: drops the parity bits and reorders the key into the C and D halves.
  function automatic logic [55:0] pc1_permute(input logic [63:0] key);
    logic [55:0] res;
    int unsigned j;
    int unsigned b;
    res = '0;
    for (int unsigned i = 0; i < 56; i++) begin
      j = int'(PC1_SEL[i]);
      b = j + j / 7;
      res[55 - i] = key[63 - b];
    end
    return res;
  endfunction

  // PC-2: picks the 48 subkey bits out of the rotated halves.
  function automatic logic [47:0] pc2_compress(input logic [55:0] cd);
    logic [47:0] res;
    res = '0;
    for (int unsigned i = 0; i < 48; i++) begin
      res[47 - i] = cd[55 - int'(PC2_SEL[i])];
    end
    return res;
  endfunction

  // Rotates one 28-bit half left by one or two places.
  function automatic logic [27:0] rotl_half(input logic [27:0] x, input logic [1:0] s);
    logic [27:0] res;
    if (s == 2'd2) begin
      res = {x[25:0], x[27:26]};
    end else begin
      res = {x[26:0], x[27]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/des_rks_stream_if.sv =====
// Valid/ready stream interface carrying one payload of type T per transfer.
// Used for both the request and the response channels; no dependencies.
`default_nettype none

interface des_rks_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== rtl/des_rks_ctrl.sv =====
// Controller of the DES key schedule: sequences load, rotation and output steps
// and owns the output valid flag. Depends on des_rks_pkg and the assertion header.
`default_nettype none

`include "des_round_key_schedule_core_assert.svh"

module des_rks_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  input  des_rks_pkg::dp_status_t status_i,
  output des_rks_pkg::ctrl_cmd_t  cmd_o
);
  import des_rks_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROT  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;
  logic       accept;

  // The output register can take a result when it is empty or being drained.
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_FIN) && slot_free);
  assign accept     = in_valid_i && in_ready_o;

  // Datapath commands.
  assign cmd_o.load   = accept;
  assign cmd_o.rotate = (state_q == ST_ROT);
  assign cmd_o.emit   = (state_q == ST_FIN) && slot_free;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_ROT;
        end
      end
      ST_ROT: begin
        if (status_i.last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          state_d = accept ? ST_ROT : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid is set by a result write and cleared by a transfer.
  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // An accepted item always starts rotating in the next cycle.
  `DES_RKS_ASSERT(a_accept_starts_rot, clk_i, rst_ni, accept |=> (state_q == ST_ROT))
  // A result is written only into a free output register.
  `DES_RKS_ASSERT(a_emit_slot_free, clk_i, rst_ni, cmd_o.emit |-> (!out_valid_q || out_ready_i))
  // A written result is offered in the next cycle.
  `DES_RKS_ASSERT(a_emit_shows_valid, clk_i, rst_ni, cmd_o.emit |=> out_valid_o)
  // The last rotation step hands over to the output step.
  `DES_RKS_ASSERT(a_last_goes_fin, clk_i, rst_ni,
    ((state_q == ST_ROT) && status_i.last) |=> (state_q == ST_FIN))
  // Loading and rotating never coincide.
  `DES_RKS_ASSERT_ALWAYS(a_load_not_rot, clk_i, !(cmd_o.load && cmd_o.rotate))

endmodule

`default_nettype wire

// ===== rtl/des_rks_dp.sv =====
// Datapath of the DES key schedule: PC-1 load, per-round half rotation,
// round counter and PC-2 output register. Depends on des_rks_pkg.
`default_nettype none

module des_rks_dp (
  input  wire                      clk_i,
  input  des_rks_pkg::ctrl_cmd_t   cmd_i,
  input  des_rks_pkg::key_req_t    req_data_i,
  output des_rks_pkg::dp_status_t  status_o,
  output des_rks_pkg::subkey_rsp_t rsp_data_o
);
  import des_rks_pkg::*;

  logic [27:0] c_q, d_q;
  logic [3:0]  rnd_q;
  logic [3:0]  cnt_q;
  logic [47:0] sub_q;
  logic [55:0] k56;

  assign k56 = pc1_permute(req_data_i.cipher_key);

  // The current step is the requested round's own shift.
  assign status_o.last = (cnt_q == rnd_q);

  // Key halves and round counter.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_q   <= k56[55:28];
      d_q   <= k56[27:0];
      rnd_q <= req_data_i.round_index;
      cnt_q <= '0;
    end else if (cmd_i.rotate) begin
      c_q   <= rotl_half(c_q, ROT_PER_ROUND[cnt_q]);
      d_q   <= rotl_half(d_q, ROT_PER_ROUND[cnt_q]);
      cnt_q <= cnt_q + 4'd1;
    end
  end

  // Output register, written from the fully rotated halves.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      sub_q <= pc2_compress({c_q, d_q});
    end
  end

  assign rsp_data_o.round_subkey = sub_q;

endmodule

`default_nettype wire

// ===== rtl/des_round_key_schedule_core.sv =====
// DES round key schedule: returns one round's 48-bit subkey for a 64-bit key.
//
// Channels: req_i carries cipher_key and round_index; rsp_o carries
// round_subkey. Both are valid/ready; a transfer happens on a rising edge of
// clk_i with valid and ready high. Every request gives exactly one response.
// The request is permuted by PC-1 as it is taken, the halves are then rotated
// by one round's shift per cycle for rounds 0 through round_index, and PC-2
// writes the subkey into the output register once that register is free.
// A new request is taken only while idle or at the output step, so one key's
// rotation is finished before the next key is loaded.
// The next request is taken in the cycle the previous subkey is written.
// While a subkey waits in the output register a new request is accepted and
// rotated; it then holds at its output step until rsp_o is drained.
// Reset (rst_ni low, asynchronous) clears the controller state and the output valid flag; key registers are not reset.
// Depends on des_rks_pkg, des_rks_stream_if, des_rks_ctrl and des_rks_dp.
`default_nettype none

module des_round_key_schedule_core (
  input  wire              clk_i,
  input  wire              rst_ni,
  des_rks_stream_if.sink   req_i,
  des_rks_stream_if.source rsp_o
);
  import des_rks_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  des_rks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  des_rks_dp u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .req_data_i (req_i.data),
    .status_o   (status),
    .rsp_data_o (rsp_o.data)
  );

endmodule

`default_nettype wire
